// ===== rtl/ubt_pkg.sv =====
// Shared types, codes and constants for the UF2 block tracker.
// No dependencies; every module of the block imports this package.
package ubt_pkg;

    localparam int BLOCKS_MAX = 4096;
    localparam int IDX_W      = $clog2(BLOCKS_MAX);
    localparam int ROW_W      = (BLOCKS_MAX < 32) ? BLOCKS_MAX : 32;
    localparam int ROWS       = BLOCKS_MAX / ROW_W;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_AW     = $clog2(ROW_W);

    localparam logic [31:0] MAGIC_A        = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_B        = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_Z        = 32'h0AB1_6F30;
    localparam int          FLAG_FAMILY    = 13;
    localparam int          FLAG_NOT_MAIN  = 0;
    localparam logic [8:0]  PAYLOAD_LIMIT  = 9'd476;
    localparam logic [16:0] CAP_LIMIT      = 17'd65536;
    localparam logic [16:0] CAP_RESET      = 17'd4096;
    localparam logic [31:0] TOTAL_CONFLICT = 32'hFFFF_FFFF;

    // opcodes of an input beat
    localparam logic [1:0] OPC_BLOCK = 2'd0;
    localparam logic [1:0] OPC_POLL  = 2'd1;
    localparam logic [1:0] OPC_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic REG_FAMILY_ID = 1'b0;
    localparam logic REG_CACHE_CAP = 1'b1;

    typedef enum logic [2:0] {
        K_APPEND       = 3'd0,
        K_FLUSH        = 3'd1,
        K_BAD_HEADER   = 3'd2,
        K_WRONG_FAMILY = 3'd3,
        K_REJECT       = 3'd4,
        K_POLL_STATUS  = 3'd5,
        K_CLEARED      = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        CL_BLOCK,
        CL_POLL,
        CL_CLEAR,
        CL_BAD,
        CL_FAMILY,
        CL_RANGE
    } cls_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_APPEND,
        S_POLL_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] magic_start0;
        logic [31:0] magic_start1;
        logic [31:0] magic_end;
        logic [31:0] flags;
        logic [31:0] family;
        logic [31:0] target_address;
        logic [8:0]  payload_size;
        logic [31:0] block_index;
        logic [31:0] total_blocks;
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [16:0] length;
        logic [15:0] cache_offset;
        logic [12:0] blocks_written;
        logic        done_res;
        logic        last;
    } res_t;

    typedef struct packed {
        cls_t             cls;
        logic [31:0]      addr;
        logic [8:0]       size;
        logic [IDX_W-1:0] idx;
        logic [31:0]      total;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ===== rtl/ubt_front.sv =====
// Front end: takes command beats, checks the header and classifies it.
// Holds the family_id register. Depends on ubt_pkg.
module ubt_front
    import ubt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output logic        push,
    output q_entry_t    entry
);

    logic [31:0] family_id_reg;
    logic        bad_header;
    logic        out_of_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            family_id_reg <= '0;
        end
        else if (wr_en && wr_index == REG_FAMILY_ID)
        begin
            family_id_reg <= wr_data;
        end
    end

    assign bad_header = cmd.magic_start0 != MAGIC_A || cmd.magic_start1 != MAGIC_B ||
                        cmd.magic_end != MAGIC_Z || !cmd.flags[FLAG_FAMILY] ||
                        cmd.flags[FLAG_NOT_MAIN] || cmd.payload_size > PAYLOAD_LIMIT;

    assign out_of_range = cmd.total_blocks == '0 || cmd.block_index >= 32'(BLOCKS_MAX);

    always_comb
    begin
        entry.addr  = cmd.target_address;
        entry.size  = cmd.payload_size;
        entry.idx   = cmd.block_index[IDX_W-1:0];
        entry.total = cmd.total_blocks;
        entry.cls   = CL_BLOCK;
        push        = start && !busy;
        unique case (cmd.opcode)
            OPC_BLOCK:
            begin
                if (bad_header)
                    entry.cls = CL_BAD;
                else if (cmd.family != family_id_reg)
                    entry.cls = CL_FAMILY;
                else if (out_of_range)
                    entry.cls = CL_RANGE;
                else
                    entry.cls = CL_BLOCK;
            end
            OPC_POLL:  entry.cls = CL_POLL;
            OPC_CLEAR: entry.cls = CL_CLEAR;
            default:   push = 1'b0;  // drop undefined opcode
        endcase
    end

endmodule

// ===== rtl/ubt_queue.sv =====
// Two-entry queue that decouples the classifier from the sequencer.
// Depends on ubt_pkg for the entry type.
module ubt_queue
    import ubt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  q_entry_t  din,
    input  logic      pop,
    output q_entry_t  dout,
    output q_status_t status
);

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign status.empty = count_reg == 2'd0;
    assign status.full  = count_reg == 2'd2;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ===== rtl/ubt_back.sv =====
// Back end: sequencer over the seen bitmap, write cache and session counters.
// Emits result beats and holds cache_capacity. Depends on ubt_pkg.
module ubt_back
    import ubt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_entry_t    head,
    input  q_status_t   q_stat,
    output logic        pop,
    output logic        clearing,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data,
    output logic        strobe,
    output res_t        result
);

    state_t              state_reg, state_next;
    logic [ROW_AW-1:0]   clr_reg, clr_next;
    q_entry_t            cur_reg, cur_next;
    logic [31:0]         start_reg, start_next;
    logic [16:0]         fill_reg, fill_next;
    logic [31:0]         exp_reg, exp_next;
    logic [12:0]         written_reg, written_next;
    logic                done_reg, done_next;
    logic [16:0]         cap_reg;
    res_t                res_reg, res_next;
    logic                strobe_reg, strobe_next;

    logic [ROW_W-1:0]    seen_mem [ROWS];
    logic [ROW_W-1:0]    rd_row_reg;
    logic                mem_we, mem_re;
    logic [ROW_AW-1:0]   mem_waddr, mem_raddr;
    logic [ROW_W-1:0]    mem_wdata;

    logic [16:0]         cap_eff;
    logic                seen;
    logic                poll_ready;
    logic                need_flush;
    logic [12:0]         written_inc;

    assign cap_eff     = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
    assign seen        = rd_row_reg[cur_reg.idx[BIT_AW-1:0]];
    assign poll_ready  = !done_reg && exp_reg != '0 && {19'b0, written_reg} >= exp_reg;
    assign written_inc = written_reg + 13'd1;
    assign need_flush  = fill_reg != '0 &&
                         ((start_reg + {15'b0, fill_reg}) != cur_reg.addr ||
                          ({1'b0, fill_reg} + {9'b0, cur_reg.size}) > {1'b0, cap_eff});

    assign clearing = state_reg == S_CLEAR;
    assign strobe   = strobe_reg;
    assign result   = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == ROW_AW'(ROWS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    unique case (head.cls)
                        CL_BLOCK: state_next = S_LOOK;
                        CL_CLEAR: state_next = S_CLEAR;
                        CL_POLL:
                        begin
                            if (poll_ready && fill_reg != '0)
                                state_next = S_POLL_DONE;
                        end
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_LOOK:      state_next = seen ? S_IDLE : S_APPEND;
            S_APPEND:    state_next = S_IDLE;
            S_POLL_DONE: state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and result beats
    always_comb
    begin
        clr_next     = clr_reg;
        cur_next     = cur_reg;
        start_next   = start_reg;
        fill_next    = fill_reg;
        exp_next     = exp_reg;
        written_next = written_reg;
        done_next    = done_reg;
        res_next     = '0;
        res_next.blocks_written = written_reg;
        res_next.done_res       = done_reg;
        strobe_next  = 1'b0;
        pop          = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = clr_reg;
        mem_raddr    = ROW_AW'(head.idx >> BIT_AW);
        mem_wdata    = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + ROW_AW'(1);
            end
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    unique case (head.cls)
                        CL_BLOCK:
                        begin
                            mem_re = 1'b1;
                        end
                        CL_CLEAR:
                        begin
                            clr_next     = '0;
                            start_next   = '0;
                            fill_next    = '0;
                            exp_next     = '0;
                            written_next = '0;
                            done_next    = 1'b0;
                            strobe_next  = 1'b1;
                            res_next.kind           = K_CLEARED;
                            res_next.blocks_written = '0;
                            res_next.done_res       = 1'b0;
                            res_next.last           = 1'b1;
                        end
                        CL_POLL:
                        begin
                            strobe_next = 1'b1;
                            if (poll_ready)
                            begin
                                done_next         = 1'b1;
                                res_next.done_res = 1'b1;
                            end
                            if (poll_ready && fill_reg != '0)
                            begin
                                // final flush goes out ahead of the status beat
                                fill_next             = '0;
                                res_next.kind         = K_FLUSH;
                                res_next.address      = start_reg;
                                res_next.length       = fill_reg;
                            end
                            else
                            begin
                                res_next.kind = K_POLL_STATUS;
                                res_next.last = 1'b1;
                            end
                        end
                        CL_BAD:
                        begin
                            strobe_next   = 1'b1;
                            res_next.kind = K_BAD_HEADER;
                            res_next.last = 1'b1;
                        end
                        CL_FAMILY:
                        begin
                            strobe_next   = 1'b1;
                            res_next.kind = K_WRONG_FAMILY;
                            res_next.last = 1'b1;
                        end
                        default:
                        begin
                            strobe_next   = 1'b1;
                            res_next.kind = K_REJECT;
                            res_next.last = 1'b1;
                        end
                    endcase
                end
            end
            S_LOOK:
            begin
                if (seen)
                begin
                    strobe_next   = 1'b1;
                    res_next.kind = K_REJECT;
                    res_next.last = 1'b1;
                end
                else if (need_flush)
                begin
                    fill_next               = '0;
                    strobe_next             = 1'b1;
                    res_next.kind           = K_FLUSH;
                    res_next.address        = start_reg;
                    res_next.length         = fill_reg;
                    res_next.blocks_written = written_inc;
                end
            end
            S_APPEND:
            begin
                strobe_next             = 1'b1;
                res_next.kind           = K_APPEND;
                res_next.address        = cur_reg.addr;
                res_next.length         = {8'b0, cur_reg.size};
                res_next.cache_offset   = fill_reg[15:0];
                res_next.blocks_written = written_inc;
                res_next.last           = 1'b1;
                start_next   = cur_reg.addr - {15'b0, fill_reg};
                fill_next    = fill_reg + {8'b0, cur_reg.size};
                written_next = written_inc;
                if (exp_reg != cur_reg.total)
                begin
                    if (cur_reg.total >= 32'(BLOCKS_MAX) || exp_reg != '0)
                        exp_next = TOTAL_CONFLICT;
                    else
                        exp_next = cur_reg.total;
                end
                // mark the block seen in the row fetched during lookup
                mem_we    = 1'b1;
                mem_waddr = ROW_AW'(cur_reg.idx >> BIT_AW);
                mem_wdata = rd_row_reg | (ROW_W'(1) << cur_reg.idx[BIT_AW-1:0]);
            end
            S_POLL_DONE:
            begin
                strobe_next   = 1'b1;
                res_next.kind = K_POLL_STATUS;
                res_next.last = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            seen_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_row_reg <= seen_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            start_reg   <= '0;
            fill_reg    <= '0;
            exp_reg     <= '0;
            written_reg <= '0;
            done_reg    <= 1'b0;
            cap_reg     <= CAP_RESET;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            start_reg   <= start_next;
            fill_reg    <= fill_next;
            exp_reg     <= exp_next;
            written_reg <= written_next;
            done_reg    <= done_next;
            strobe_reg  <= strobe_next;
            if (wr_en && wr_index == REG_CACHE_CAP)
                cap_reg <= wr_data[16:0];
        end
    end

`ifndef ASSERT_OFF
    a_nonfinal_followed: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !res_reg.last |=> strobe_reg)
        else $error("non-final result beat not followed by another beat");

    a_append_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && res_reg.kind == K_APPEND |-> res_reg.last)
        else $error("append beat must close its item");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CAP_LIMIT)
        else $error("cache fill beyond 64 KiB");

    a_done_from_poll: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg == S_IDLE && head.cls == CL_POLL))
        else $error("done raised outside a poll");
`endif

endmodule

// ===== rtl/uf2_block_tracker.sv =====
// UF2 block tracker: checks UF2 block headers and issues write-cache commands.
// Top level; instantiates ubt_front, ubt_queue and ubt_back. Depends on ubt_pkg.
//
// Command channel: a beat (block header, completion poll or new session) is
// taken at a clock edge with start high and busy low. busy is high while the
// two-entry command queue is full or the seen bitmap is being cleared.
// Result channel: each result beat shows on result for one cycle with strobe
// high; result.last marks the final beat of a command. The receiver cannot
// stall, so beats are never held back.
// Result order with the queue empty: a header reject, poll or new-session beat
// is registered from the idle state that pops the command; a duplicate's reject
// comes from lookup; an accepted block's flush (if any) from lookup, its append
// from the append state. Accepted blocks pass row read, flush decision, append;
// no new command is taken from the queue until the sequencer is back in idle.
// The seen bitmap is a 128-row memory cleared one row a cycle: after reset and
// after each new-session command busy stays high until the last row is cleared.
// Configuration: wr_en/wr_index/wr_data write family_id (0) or cache_capacity
// (1); write them only while no command is in flight.
module uf2_block_tracker
    import ubt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        strobe,
    output res_t        result,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);

    logic      push;
    logic      pop;
    logic      clearing;
    q_entry_t  entry;
    q_entry_t  head;
    q_status_t q_stat;

    assign busy = q_stat.full || clearing;

    ubt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .entry    (entry)
    );

    ubt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (entry),
        .pop    (pop),
        .dout   (head),
        .status (q_stat)
    );

    ubt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .clearing (clearing),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .strobe   (strobe),
        .result   (result)
    );

endmodule
